[src/vcsd_pkg.sv]
package vcsd_pkg;

  localparam int TIME_BITS = 32;
  localparam int NUM_REC   = 3;

  typedef logic [TIME_BITS-1:0] stamp_t;
  typedef logic signed [20:0]   metric_value_t;
  typedef logic [1:0]           rec_count_t;
  typedef logic [1:0]           cfg_index_t;
  typedef logic [15:0]          cfg_data_t;

  typedef enum logic [3:0] {
    MET_ENERGY   = 4'd0,
    MET_CHARGE   = 4'd1,
    MET_MOTOR    = 4'd2,
    MET_INVERTER = 4'd3,
    MET_POWER    = 4'd4,
    MET_SPEED    = 4'd5,
    MET_LEFT     = 4'd6,
    MET_RIGHT    = 4'd7,
    MET_FAN      = 4'd8,
    MET_POWERED  = 4'd9,
    MET_GEAR     = 4'd10,
    MET_ECO      = 4'd11,
    MET_CHARGING = 4'd12
  } metric_code_t;

  localparam logic [10:0] ID_ENERGY  = 11'h5bc;
  localparam logic [10:0] ID_CHARGE  = 11'h55b;
  localparam logic [10:0] ID_TEMPS   = 11'h55a;
  localparam logic [10:0] ID_BATTERY = 11'h1db;
  localparam logic [10:0] ID_SPEEDS  = 11'h284;
  localparam logic [10:0] ID_FAN     = 11'h54b;
  localparam logic [10:0] ID_STATUS  = 11'h11a;
  localparam logic [10:0] ID_CHARGER = 11'h1d4;

  localparam cfg_index_t CFG_POWER_INTERVAL = 2'd0;
  localparam cfg_index_t CFG_WHEEL_INTERVAL = 2'd1;
  localparam cfg_index_t CFG_ENERGY_LIMIT   = 2'd2;

  localparam logic [15:0] POWER_INTERVAL_RESET = 16'd80;
  localparam logic [15:0] WHEEL_INTERVAL_RESET = 16'd100;
  localparam logic [9:0]  ENERGY_LIMIT_RESET   = 10'd1000;

  // reciprocal constants for divide by 100, by 10 and the F to C rounding
  localparam logic [16:0] RECIP_100     = 17'd83887;
  localparam int          RECIP_100_SH  = 23;
  localparam logic [15:0] RECIP_10      = 16'd52429;
  localparam int          RECIP_10_SH   = 19;
  localparam logic [19:0] TEMP_MUL      = 20'd728200;
  localparam logic [16:0] TEMP_BIAS     = 17'd58256;
  localparam int          TEMP_SH       = 17;

  typedef struct packed {
    metric_code_t  code;
    metric_value_t value;
  } rec_t;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte1;
    logic [7:0]  data_byte2;
    logic [7:0]  data_byte3;
    logic [7:0]  data_byte4;
    logic [7:0]  data_byte5;
    logic [7:0]  data_byte6;
    logic [31:0] time_ms;
  } frame_t;

  typedef struct packed {
    logic [15:0] power_interval_ms;
    logic [15:0] wheel_interval_ms;
    logic [9:0]  energy_units_limit;
  } cfg_t;

  typedef struct packed {
    logic   powered_flag;
    stamp_t power_last_time;
    stamp_t left_last_time;
    stamp_t right_last_time;
  } state_t;

  typedef struct packed {
    rec_count_t            n;
    rec_t [NUM_REC-1:0]    rec;
    state_t                state_next;
  } dec_t;

endpackage

[src/vcsd_if.sv]
interface vcsd_frame_if;
  logic        valid;
  logic        ready;
  logic [10:0] frame_id;
  logic [7:0]  data_byte0;
  logic [7:0]  data_byte1;
  logic [7:0]  data_byte2;
  logic [7:0]  data_byte3;
  logic [7:0]  data_byte4;
  logic [7:0]  data_byte5;
  logic [7:0]  data_byte6;
  logic [7:0]  data_byte7;
  logic [31:0] time_ms;

  modport source (
    output valid, frame_id, data_byte0, data_byte1, data_byte2, data_byte3,
           data_byte4, data_byte5, data_byte6, data_byte7, time_ms,
    input  ready
  );
  modport sink (
    input  valid, frame_id, data_byte0, data_byte1, data_byte2, data_byte3,
           data_byte4, data_byte5, data_byte6, data_byte7, time_ms,
    output ready
  );
endinterface

interface vcsd_metric_if;
  import vcsd_pkg::*;
  logic          valid;
  logic          ready;
  logic [3:0]    metric_code;
  metric_value_t metric_value;
  logic          last_of_frame;

  modport source (
    output valid, metric_code, metric_value, last_of_frame,
    input  ready
  );
  modport sink (
    input  valid, metric_code, metric_value, last_of_frame,
    output ready
  );
endinterface

interface vcsd_cfg_if;
  import vcsd_pkg::*;
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

[src/vehicle_can_signal_decoder_top.sv]
// Vehicle CAN signal decoder.
// frame  : sink channel, one received CAN frame per beat (identifier, eight
//          payload bytes, millisecond arrival time).
// metric : source channel, one metric update record per beat; the final
//          record caused by a frame carries last_of_frame. A frame yields
//          zero to three records.
// cfg    : register write channel, always ready; index 0 power interval,
//          1 wheel interval, 2 energy unit limit, other indexes are dropped.
// Flow   : a taken frame beat is held in the input register, then its records
//          enter the record buffer; with metric.ready high, back-to-back frames
//          that yield records stream at one record per cycle.
// The input register and the three-entry record buffer form two stages; the
// next frame is decoded while the current frame's records drain, and state
// (powered flag, last update times) is committed as a frame enters the buffer.
// A stalled metric channel holds the current record; one more frame is held
// in the input register and frame.ready then drops.
// Reset (synchronous) empties both stages, clears the powered flag and the
// last update times and restores the register reset values.
module vehicle_can_signal_decoder_top (
  input logic           clk,
  input logic           rst,
  vcsd_frame_if.sink    frame,
  vcsd_metric_if.source metric,
  vcsd_cfg_if.sink      cfg
);
  import vcsd_pkg::*;

  frame_t               frame_reg;
  logic                 frame_valid;
  cfg_t                 cfg_reg;
  state_t               state;
  dec_t                 dec;
  rec_t [NUM_REC-1:0]   rec_buf;
  rec_count_t           rec_n;
  rec_count_t           rec_head;
  logic                 pop;
  logic                 pop_last;
  logic                 load;
  logic                 buf_free;

  vcsd_decode u_decode (
    .frame (frame_reg),
    .cfg   (cfg_reg),
    .state (state),
    .dec   (dec)
  );

  assign pop      = metric.valid && metric.ready;
  assign pop_last = pop && (rec_head == rec_count_t'(rec_n - 2'd1));
  assign buf_free = (rec_n == 2'd0) || pop_last;
  assign load     = frame_valid && buf_free;

  assign frame.ready = !frame_valid || load;
  assign cfg.ready   = 1'b1;

  assign metric.valid         = rec_n != 2'd0;
  assign metric.metric_code   = rec_buf[rec_head].code;
  assign metric.metric_value  = rec_buf[rec_head].value;
  assign metric.last_of_frame = rec_head == rec_count_t'(rec_n - 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (frame.valid && frame.ready) begin
      frame_valid <= 1'b1;
    end else if (load) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      frame_reg.frame_id   <= frame.frame_id;
      frame_reg.data_byte0 <= frame.data_byte0;
      frame_reg.data_byte1 <= frame.data_byte1;
      frame_reg.data_byte2 <= frame.data_byte2;
      frame_reg.data_byte3 <= frame.data_byte3;
      frame_reg.data_byte4 <= frame.data_byte4;
      frame_reg.data_byte5 <= frame.data_byte5;
      frame_reg.data_byte6 <= frame.data_byte6;
      frame_reg.time_ms    <= frame.time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_n    <= 2'd0;
      rec_head <= 2'd0;
      state    <= '0;
    end else if (load) begin
      rec_n    <= dec.n;
      rec_head <= 2'd0;
      state    <= dec.state_next;
    end else if (pop_last) begin
      rec_n    <= 2'd0;
      rec_head <= 2'd0;
    end else if (pop) begin
      rec_head <= rec_count_t'(rec_head + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_buf <= dec.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.power_interval_ms  <= POWER_INTERVAL_RESET;
      cfg_reg.wheel_interval_ms  <= WHEEL_INTERVAL_RESET;
      cfg_reg.energy_units_limit <= ENERGY_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_POWER_INTERVAL: cfg_reg.power_interval_ms  <= cfg.data;
        CFG_WHEEL_INTERVAL: cfg_reg.wheel_interval_ms  <= cfg.data;
        CFG_ENERGY_LIMIT:   cfg_reg.energy_units_limit <= cfg.data[9:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[src/vcsd_decode.sv]
module vcsd_decode (
  input  vcsd_pkg::frame_t frame,
  input  vcsd_pkg::cfg_t   cfg,
  input  vcsd_pkg::state_t state,
  output vcsd_pkg::dec_t   dec
);
  import vcsd_pkg::*;

  function automatic metric_value_t temp_tenths(input logic [7:0] b);
    logic [7:0]  e;
    logic [27:0] prod;
    logic [10:0] q;
    begin
      e    = (b >= 8'd32) ? (b - 8'd32) : (8'd32 - b);
      prod = 28'(e * TEMP_MUL) + 28'(TEMP_BIAS);
      q    = prod[TEMP_SH +: 11];
      temp_tenths = (b >= 8'd32) ? metric_value_t'({10'd0, q})
                                 : -metric_value_t'({10'd0, q});
    end
  endfunction

  logic [9:0]          raw10;
  logic signed [10:0]  current;
  logic [9:0]          volts;
  logic signed [21:0]  pw_prod;
  logic [15:0]         lsp;
  logic [15:0]         rsp;
  logic [15:0]         rear;
  logic [32:0]         rear_prod;
  logic [31:0]         lsp_prod;
  logic [31:0]         rsp_prod;
  stamp_t              t;
  logic                power_ok;
  logic                left_ok;
  logic                right_ok;
  logic [2:0]          charge_state;
  metric_value_t       power_val;
  metric_value_t       left_val;
  metric_value_t       right_val;

  assign raw10     = {frame.data_byte0, frame.data_byte1[7:6]};
  assign current   = $signed({frame.data_byte0, frame.data_byte1[7:5]});
  assign volts     = {frame.data_byte2, frame.data_byte3[7:6]};
  assign pw_prod   = current * $signed({1'b0, volts});
  assign power_val = metric_value_t'(-pw_prod);

  assign lsp       = {frame.data_byte0, frame.data_byte1};
  assign rsp       = {frame.data_byte2, frame.data_byte3};
  assign rear      = {frame.data_byte4, frame.data_byte5};
  assign rear_prod = rear * RECIP_100;
  assign lsp_prod  = lsp * RECIP_10;
  assign rsp_prod  = rsp * RECIP_10;
  assign left_val  = metric_value_t'(lsp_prod[RECIP_10_SH +: 13]);
  assign right_val = metric_value_t'(rsp_prod[RECIP_10_SH +: 13]);

  assign t        = stamp_t'(frame.time_ms);
  assign power_ok = stamp_t'(t - stamp_t'(cfg.power_interval_ms)) >= state.power_last_time;
  assign left_ok  = stamp_t'(t - stamp_t'(cfg.wheel_interval_ms)) >= state.left_last_time;
  assign right_ok = stamp_t'(t - stamp_t'(cfg.wheel_interval_ms)) >= state.right_last_time;

  assign charge_state = frame.data_byte6[7:5];

  always_comb begin
    dec            = '0;
    dec.state_next = state;
    unique case (frame.frame_id)
      ID_ENERGY: begin
        if (raw10 < cfg.energy_units_limit) begin
          dec.n      = 2'd1;
          dec.rec[0] = '{MET_ENERGY, metric_value_t'(raw10)};
        end
      end
      ID_CHARGE: begin
        dec.n      = 2'd1;
        dec.rec[0] = '{MET_CHARGE, metric_value_t'(raw10)};
      end
      ID_TEMPS: begin
        dec.n      = 2'd2;
        dec.rec[0] = '{MET_MOTOR, temp_tenths(frame.data_byte1)};
        dec.rec[1] = '{MET_INVERTER, temp_tenths(frame.data_byte2)};
      end
      ID_BATTERY: begin
        if (state.powered_flag && power_ok) begin
          dec.n                          = 2'd1;
          dec.rec[0]                     = '{MET_POWER, power_val};
          dec.state_next.power_last_time = t;
        end
      end
      ID_SPEEDS: begin
        dec.rec[0] = '{MET_SPEED, metric_value_t'(rear_prod[RECIP_100_SH +: 10])};
        if (left_ok) begin
          dec.state_next.left_last_time = t;
        end
        if (right_ok) begin
          dec.state_next.right_last_time = t;
        end
        priority if (left_ok && right_ok) begin
          dec.n      = 2'd3;
          dec.rec[1] = '{MET_LEFT, left_val};
          dec.rec[2] = '{MET_RIGHT, right_val};
        end else if (left_ok) begin
          dec.n      = 2'd2;
          dec.rec[1] = '{MET_LEFT, left_val};
        end else if (right_ok) begin
          dec.n      = 2'd2;
          dec.rec[1] = '{MET_RIGHT, right_val};
        end else begin
          dec.n = 2'd1;
        end
      end
      ID_FAN: begin
        dec.n      = 2'd1;
        dec.rec[0] = '{MET_FAN, metric_value_t'(frame.data_byte4[7:3])};
      end
      ID_STATUS: begin
        dec.n                       = 2'd3;
        dec.rec[0]                  = '{MET_POWERED, metric_value_t'(frame.data_byte1[6])};
        dec.rec[1]                  = '{MET_GEAR, metric_value_t'(frame.data_byte0[7:4])};
        dec.rec[2]                  = '{MET_ECO, metric_value_t'(frame.data_byte1[4])};
        dec.state_next.powered_flag = frame.data_byte1[6];
      end
      ID_CHARGER: begin
        dec.n      = 2'd1;
        dec.rec[0] = '{MET_CHARGING,
                       metric_value_t'((charge_state == 3'd6) || (charge_state == 3'd7))};
      end
      default: begin
        dec.n = 2'd0;
      end
    endcase
  end

endmodule
